// ----- rtl/fmq_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package fmq_pkg;

   // Matrix geometry
   localparam int MAX_DIM_DEFAULT = 4096;
   localparam int DIM_CSR_W       = 13;
   localparam int DEST_W          = 24;

   // Control register port
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 32;

   localparam logic [CSR_INDEX_W-1:0] CSR_SCALE     = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_NARROW    = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_TRANSPOSE = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_ROWS      = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_COLS      = 3'd4;

   localparam logic [31:0] SCALE_RESET = 32'h3F80_0000;

   // Saturation limits
   localparam logic [19:0] WIDE_MAX  = 20'd32767;
   localparam logic [19:0] WIDE_NEG  = 20'd32768;
   localparam logic [19:0] NARROW_MAX = 20'd127;
   localparam logic [19:0] NARROW_NEG = 20'd128;

   // Settings the conversion datapath needs
   typedef struct packed {
      logic [31:0] scale;
      logic        narrow;
   } conv_cfg_type;

endpackage

`default_nettype wire

// ----- rtl/fmq_convert.sv -----
`timescale 1ns / 1ps
`default_nettype none

module fmq_convert
   import fmq_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         advance,
   input  wire logic [31:0]  sample,
   input  wire conv_cfg_type cfg,
   output logic [15:0]       quantized
);

   localparam logic [42:0] HALF = 43'h1 << 24;

   // ---------------- stage 1: unpack and multiply ----------------
   logic [7:0]  xe, se;
   logic [22:0] xf, sf;
   logic        x_zero, x_inf, x_nan, s_zero, s_inf, s_nan;
   logic [23:0] xm, sm;
   logic signed [9:0] xexp, sexp;
   logic        nan_in, inf_in;

   always_comb begin
      xe = sample[30:23];
      xf = sample[22:0];
      se = cfg.scale[30:23];
      sf = cfg.scale[22:0];
      x_zero = (xe == 8'd0) && (xf == '0);
      s_zero = (se == 8'd0) && (sf == '0);
      x_inf  = (xe == 8'hFF) && (xf == '0);
      s_inf  = (se == 8'hFF) && (sf == '0);
      x_nan  = (xe == 8'hFF) && (xf != '0);
      s_nan  = (se == 8'hFF) && (sf != '0);
      xm = {xe != 8'd0, xf};
      sm = {se != 8'd0, sf};
      // unbiased exponent of the integer significand, subnormals use 1
      xexp = signed'({2'b0, (xe == 8'd0) ? 8'd1 : xe}) - 10'sd150;
      sexp = signed'({2'b0, (se == 8'd0) ? 8'd1 : se}) - 10'sd150;
      nan_in = x_nan || s_nan || (x_inf && s_zero) || (s_inf && x_zero);
      inf_in = (x_inf || s_inf) && !nan_in;
   end

   logic [47:0]       prod_ff;
   logic signed [9:0] shift_ff;
   logic              sign_ff, rneg_ff, nan_ff, inf_ff, narrow_ff;

   always_ff @(posedge clock) begin
      if (advance) begin
         prod_ff   <= xm * sm;
         // exponent of the product scaled by 2^25
         shift_ff  <= xexp + sexp + 10'sd25;
         sign_ff   <= sample[31] ^ cfg.scale[31];
         rneg_ff   <= sample[31] && !x_zero;
         nan_ff    <= nan_in;
         inf_ff    <= inf_in;
         narrow_ff <= cfg.narrow;
      end
   end

   // ---------------- stage 2: align, add offset, round, saturate ----------------
   logic [90:0] lwide;
   logic [47:0] rwide;
   logic [9:0]  rsh;
   logic [42:0] ap;
   logic        big, sticky;
   logic [43:0] a;
   logic        vneg;
   logic [18:0] m;
   logic [24:0] frac;
   logic [4:0]  msb;
   logic [25:0] h25, gap;
   logic        up;
   logic [19:0] mag, lim_pos, lim_neg;
   logic [15:0] q;

   always_comb begin
      lwide  = '0;
      rwide  = '0;
      rsh    = '0;
      ap     = '0;
      big    = 1'b0;
      sticky = 1'b0;
      // fixed point |p| * 2^25, floor, with sticky for dropped bits
      if (!shift_ff[9]) begin
         if (shift_ff > 10'sd43) begin
            big = (prod_ff != '0);
         end else begin
            lwide = {43'b0, prod_ff} << shift_ff[5:0];
            big   = (lwide[90:43] != '0);
            ap    = lwide[42:0];
         end
      end else begin
         rsh = unsigned'(-shift_ff);
         if (rsh >= 10'd48) begin
            sticky = (prod_ff != '0);
         end else begin
            rwide  = prod_ff >> rsh[5:0];
            sticky = ((prod_ff & ~({48{1'b1}} << rsh[5:0])) != '0);
            big    = (rwide[47:43] != '0);
            ap     = rwide[42:0];
         end
      end

      // add +-0.5, giving floor of |v| * 2^25 and the sign of v
      if (sign_ff == rneg_ff) begin
         a    = {1'b0, ap} + {1'b0, HALF};
         vneg = sign_ff;
      end else if (ap >= HALF) begin
         a    = {1'b0, ap - HALF};
         vneg = sign_ff;
      end else begin
         a    = {1'b0, HALF - ap - 43'(sticky)};
         vneg = !sign_ff;
      end

      m    = a[43:25];
      frac = a[24:0];
      msb  = '0;
      for (int i = 0; i < 19; i++) begin
         if (m[i]) msb = 5'(i);
      end
      // half ulp just below m+1, in units of 2^-25
      h25  = (m == '0) ? 26'd1 : (26'd1 << (msb + 5'd1));
      gap  = 26'h200_0000 - {1'b0, frac};
      up   = (frac != '0) && (gap <= h25);
      mag  = {1'b0, m} + 20'(up);

      lim_pos = narrow_ff ? NARROW_MAX : WIDE_MAX;
      lim_neg = narrow_ff ? NARROW_NEG : WIDE_NEG;

      if (nan_ff) begin
         q = lim_pos[15:0];
      end else if (big || inf_ff) begin
         q = sign_ff ? 16'(-lim_neg) : lim_pos[15:0];
      end else if (vneg) begin
         q = (mag > lim_neg) ? 16'(-lim_neg) : 16'(-mag);
      end else begin
         q = (mag > lim_pos) ? lim_pos[15:0] : mag[15:0];
      end
   end

   logic [15:0] quantized_ff;

   always_ff @(posedge clock) begin
      if (advance) quantized_ff <= q;
   end

   assign quantized = quantized_ff;

endmodule

`default_nettype wire

// ----- rtl/float_matrix_quantizer.sv -----
// Pipeline: an input is registered in the multiplier stage and then in the
// rounding/saturation stage, which offers it on rsp_ (two register stages).
// Throughput: one element per cycle; the multiplier stage and the
// rounding/saturation stage form a two-deep pipeline that stalls as a whole
// only while a finished result is not taken.
// Reset: clears pipeline valids and matrix counters, restores register defaults.
`timescale 1ns / 1ps
`default_nettype none

module float_matrix_quantizer
   import fmq_pkg::*;
#(
   parameter int MAX_DIM = MAX_DIM_DEFAULT
)(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_ready,
   input  wire logic [31:0]            req_sample,
   output logic                        rsp_valid,
   input  wire logic                   rsp_ready,
   output logic signed [15:0]          rsp_quantized,
   output logic [DEST_W-1:0]           rsp_dest_index,
   output logic                        rsp_matrix_end,
   input  wire logic                   csr_write_enable,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_write_data
);

   localparam int CNT_W = (MAX_DIM > 2) ? $clog2(MAX_DIM) : 1;
   localparam int CMP_W = CNT_W + 1;
   localparam int IDX_W = (2 * CMP_W > DEST_W) ? 2 * CMP_W : DEST_W;

   // Control registers
   logic [31:0]          scale_ff;
   logic                 narrow_ff, transpose_ff;
   logic [DIM_CSR_W-1:0] rows_ff, cols_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         scale_ff     <= SCALE_RESET;
         narrow_ff    <= 1'b0;
         transpose_ff <= 1'b0;
         rows_ff      <= DIM_CSR_W'(1);
         cols_ff      <= DIM_CSR_W'(1);
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_SCALE:     scale_ff     <= csr_write_data;
            CSR_NARROW:    narrow_ff    <= csr_write_data[0];
            CSR_TRANSPOSE: transpose_ff <= csr_write_data[0];
            CSR_ROWS:      rows_ff      <= csr_write_data[DIM_CSR_W-1:0];
            CSR_COLS:      cols_ff      <= csr_write_data[DIM_CSR_W-1:0];
            default: ;
         endcase
      end
   end

   // Pipeline control: everything moves unless a result is held
   logic v1_ff, v2_ff;
   logic advance, accept;

   assign advance   = !v2_ff || rsp_ready;
   assign req_ready = advance;
   assign accept    = req_valid && advance;
   assign rsp_valid = v2_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else if (advance) begin
         v1_ff <= req_valid;
         v2_ff <= v1_ff;
      end
   end

   // Clamped matrix dimensions
   logic [CMP_W-1:0] rows_c, cols_c;

   always_comb begin
      if (rows_ff == '0) rows_c = CMP_W'(1);
      else if (32'(rows_ff) > 32'(MAX_DIM)) rows_c = CMP_W'(MAX_DIM);
      else rows_c = CMP_W'(rows_ff);
      if (cols_ff == '0) cols_c = CMP_W'(1);
      else if (32'(cols_ff) > 32'(MAX_DIM)) cols_c = CMP_W'(MAX_DIM);
      else cols_c = CMP_W'(cols_ff);
   end

   // Position counters and destination index
   logic [CNT_W-1:0] row_ff, col_ff, row_in, col_in;
   logic [CMP_W-1:0] row_next, col_next;
   logic             col_wrap, row_wrap, last;
   logic [IDX_W-1:0] idx_full;

   always_comb begin
      row_next = {1'b0, row_ff} + CMP_W'(1);
      col_next = {1'b0, col_ff} + CMP_W'(1);
      col_wrap = (col_next >= cols_c);
      row_wrap = (row_next >= rows_c);
      last     = col_wrap && row_wrap;
      col_in   = col_wrap ? '0 : col_next[CNT_W-1:0];
      row_in   = row_ff;
      if (col_wrap) row_in = row_wrap ? '0 : row_next[CNT_W-1:0];
      if (transpose_ff) idx_full = IDX_W'(col_ff) * IDX_W'(rows_c) + IDX_W'(row_ff);
      else idx_full = IDX_W'(row_ff) * IDX_W'(cols_c) + IDX_W'(col_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff <= '0;
         col_ff <= '0;
      end else if (accept) begin
         row_ff <= row_in;
         col_ff <= col_in;
      end
   end

   // Index and end flag ride alongside the datapath
   logic [DEST_W-1:0] idx1_ff, idx2_ff;
   logic              end1_ff, end2_ff;

   always_ff @(posedge clock) begin
      if (advance) begin
         idx1_ff <= idx_full[DEST_W-1:0];
         end1_ff <= last;
         idx2_ff <= idx1_ff;
         end2_ff <= end1_ff;
      end
   end

   conv_cfg_type conv_cfg;
   logic [15:0]  quantized;

   assign conv_cfg.scale  = scale_ff;
   assign conv_cfg.narrow = narrow_ff;

   fmq_convert u_convert (
      .clock     (clock),
      .advance   (advance),
      .sample    (req_sample),
      .cfg       (conv_cfg),
      .quantized (quantized)
   );

   assign rsp_quantized  = signed'(quantized);
   assign rsp_dest_index = idx2_ff;
   assign rsp_matrix_end = end2_ff;

   // Checks
   a_accept_fills: assert property (@(posedge clock) disable iff (reset)
      accept |=> v1_ff)
      else $error("accepted transfer did not enter the pipeline");

   a_stage1_held: assert property (@(posedge clock) disable iff (reset)
      (v1_ff && !advance) |=> v1_ff)
      else $error("stalled item lost in stage 1");

   a_col_range: assert property (@(posedge clock) disable iff (reset)
      32'(col_ff) < 32'(MAX_DIM))
      else $error("column counter beyond maximum dimension");

   a_row_range: assert property (@(posedge clock) disable iff (reset)
      32'(row_ff) < 32'(MAX_DIM))
      else $error("row counter beyond maximum dimension");

endmodule

`default_nettype wire

// ----- sim/tb.sv -----
`timescale 1ns / 1ps

module tb;
   import fmq_pkg::*;

   typedef struct packed {
      logic        typed;
      logic [15:0] q;
      logic [31:0] sample;
   } vector_t;

   typedef struct {
      logic signed [15:0] q;
      logic [23:0]        idx;
      logic               last;
   } quant_result_t;

   localparam int NUM_WIDE   = 18;
   localparam int NUM_VECTOR = 23;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [31:0] req_sample = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic signed [15:0] rsp_quantized;
   logic [DEST_W-1:0] rsp_dest_index;
   logic rsp_matrix_end;
   logic csr_write_enable = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_write_data = '0;

   // Shadow copy of the block's registers and matrix position
   logic [31:0] model_scale;
   logic        model_narrow;
   logic        model_transpose;
   logic [12:0] model_rows;
   logic [12:0] model_cols;
   int unsigned row_pos;
   int unsigned col_pos;

   quant_result_t pending_results[$];
   vector_t directed[NUM_VECTOR];
   int mismatches = 0;
   int transfers_in = 0;
   int transfers_out = 0;
   bit idle_on = 1'b1;

   float_matrix_quantizer DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_sample(req_sample),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_quantized(rsp_quantized),
      .rsp_dest_index(rsp_dest_index), .rsp_matrix_end(rsp_matrix_end),
      .csr_write_enable(csr_write_enable), .csr_index(csr_index),
      .csr_write_data(csr_write_data)
   );

   always #10 clock = ~clock;

   initial begin
      #20ms;
      $display("FAIL");
      $finish;
   end

   // Exact value of a finite single-precision pattern
   function automatic real f32_value(logic [31:0] b);
      int e;
      real m;
      e = b[30:23];
      m = b[22:0];
      if (e != 0) begin
         m = m + 8388608.0;
      end else begin
         e = 1;
      end
      m = m * (2.0 ** (e - 150));
      return b[31] ? -m : m;
   endfunction

   // Smallest real that rounds to single at or above integer k (k >= 1)
   function automatic real round_up_point(int unsigned k);
      int j;
      real half;
      j = 0;
      while (j < 31 && (k >> (j + 1)) != 0) j++;
      half = ((k & (k - 1)) == 0) ? 2.0 ** -25 : 2.0 ** -24;
      return real'(k) - half * (2.0 ** j);
   endfunction

   // Largest k in [0, 65536] with round_to_single(y + off) >= k
   function automatic int unsigned rounded_floor(real y, real off);
      real approx;
      int unsigned k;
      if (y >= 70000.0) return 65536;
      approx = y + off;
      if (!(approx >= 0.0)) return 0;
      k = $rtoi(approx);
      k = (k > 1) ? k - 1 : 0;
      while (k < 65536 && y >= round_up_point(k + 1) - off) k++;
      return k;
   endfunction

   function automatic int unsigned dim_of(logic [12:0] d);
      if (d == 0) return 1;
      if (d > MAX_DIM_DEFAULT) return MAX_DIM_DEFAULT;
      return d;
   endfunction

   // Quantize one element and advance the matrix position
   task automatic quantize_element(input logic [31:0] x, output quant_result_t res);
      bit x_nan, s_nan, x_inf, s_inf, x_zero, s_zero;
      real p, r;
      int q, hi, lo;
      int unsigned rows, cols;
      longint unsigned idx;
      x_nan = (x[30:23] == 8'hFF) && (x[22:0] != 0);
      s_nan = (model_scale[30:23] == 8'hFF) && (model_scale[22:0] != 0);
      x_inf = (x[30:0] == 31'h7F800000);
      s_inf = (model_scale[30:0] == 31'h7F800000);
      x_zero = (x[30:0] == 0);
      s_zero = (model_scale[30:0] == 0);
      hi = model_narrow ? 127 : 32767;
      lo = model_narrow ? -128 : -32768;
      r = (x[31] && !x_zero) ? -0.5 : 0.5;
      if (x_nan || s_nan || (x_inf && s_zero) || (s_inf && x_zero)) begin
         q = hi;
      end else begin
         if (x_inf || s_inf) begin
            p = (x[31] ^ model_scale[31]) ? -1.0e300 : 1.0e300;
         end else begin
            p = f32_value(x) * f32_value(model_scale);
         end
         q = int'(rounded_floor(p, r)) - int'(rounded_floor(-p, -r));
         if (q > hi) q = hi;
         if (q < lo) q = lo;
      end
      rows = dim_of(model_rows);
      cols = dim_of(model_cols);
      if (model_transpose) begin
         idx = longint'(col_pos) * rows + row_pos;
      end else begin
         idx = longint'(row_pos) * cols + col_pos;
      end
      res.q = q[15:0];
      res.idx = idx[23:0];
      res.last = (col_pos + 1 >= cols) && (row_pos + 1 >= rows);
      col_pos++;
      if (col_pos >= cols) begin
         col_pos = 0;
         row_pos++;
         if (row_pos >= rows) row_pos = 0;
      end
   endtask

   // Send one element; a random gap may precede it
   task automatic send_sample(input logic [31:0] v, input bit typed,
                              input logic [15:0] typed_q);
      quant_result_t res;
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 9)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_sample <= v;
      do @(posedge clock); while (!req_ready);
      quantize_element(v, res);
      if (typed) res.q = typed_q;
      pending_results.push_back(res);
      transfers_in++;
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Program all registers while the block is idle
   task automatic program_regs(input logic [31:0] scale, input logic narrow,
                               input logic transp, input logic [12:0] rows,
                               input logic [12:0] cols);
      logic [31:0] vals[5];
      vals = '{scale, {31'd0, narrow}, {31'd0, transp}, {19'd0, rows}, {19'd0, cols}};
      wait_drained();
      for (int i = 0; i < 5; i++) begin
         csr_write_enable <= 1'b1;
         csr_index <= i[CSR_INDEX_W-1:0];
         csr_write_data <= vals[i];
         @(posedge clock);
      end
      csr_write_enable <= 1'b0;
      model_scale = scale;
      model_narrow = narrow;
      model_transpose = transp;
      model_rows = rows;
      model_cols = cols;
   endtask

   function automatic logic [31:0] pick_special();
      logic [31:0] s[10];
      s = '{32'h3F800000, 32'h00000000, 32'h80000000, 32'h7F800000, 32'hFF800000,
            32'h7FC00000, 32'h7F7FFFFF, 32'h00000001, 32'hBF800000, 32'h3F000000};
      return s[$urandom_range(0, 9)];
   endfunction

   function automatic logic [31:0] random_sample();
      case ($urandom_range(0, 9))
         0, 1: return $urandom;
         8: return pick_special();
         9: return {$urandom_range(0, 1) == 1, 8'($urandom_range(124, 128)),
                    2'($urandom), 21'd0};
         default: return {$urandom_range(0, 1) == 1, 8'($urandom_range(118, 141)),
                          23'($urandom)};
      endcase
   endfunction

   function automatic logic [31:0] random_scale();
      case ($urandom_range(0, 5))
         0: return pick_special();
         1: return $urandom;
         default: return {$urandom_range(0, 3) == 0, 8'($urandom_range(118, 136)),
                          23'($urandom)};
      endcase
   endfunction

   function automatic logic [12:0] random_dim();
      logic [12:0] d[8];
      d = '{13'd0, 13'd1, 13'd2, 13'd4096, 13'd4097, 13'd8191, 13'd3, 13'd7};
      if ($urandom_range(0, 2) == 0) return d[$urandom_range(0, 7)];
      return 13'($urandom_range(1, 12));
   endfunction

   // Result side: random stall bursts, then check against the oldest expectation
   int stall_left = 0;
   always @(posedge clock) begin
      quant_result_t want;
      if (!reset && rsp_valid && rsp_ready) begin
         transfers_out++;
         if (pending_results.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result transfer q=%0d", rsp_quantized);
         end else begin
            want = pending_results.pop_front();
            if (rsp_quantized !== want.q || rsp_dest_index !== want.idx ||
                rsp_matrix_end !== want.last) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: expected q=%0d idx=%0d end=%0b, got q=%0d idx=%0d end=%0b",
                           want.q, want.idx, want.last,
                           rsp_quantized, rsp_dest_index, rsp_matrix_end);
            end
         end
      end
      if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 4) == 0) begin
         stall_left <= $urandom_range(0, 8);
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   initial begin
      int phases;
      int count;
      directed = '{
         '{1'b1, 16'd0,      32'h00000000}, '{1'b1, 16'd0,      32'h80000000},
         '{1'b1, 16'd1,      32'h3F800000}, '{1'b1, 16'd1,      32'h3F000000},
         '{1'b1, 16'hFFFF,   32'hBF000000}, '{1'b1, 16'd3,      32'h40200000},
         '{1'b1, 16'hFFFD,   32'hC0200000}, '{1'b1, 16'h7FFF,   32'h7F800000},
         '{1'b1, 16'h8000,   32'hFF800000}, '{1'b1, 16'h7FFF,   32'h7FC00000},
         '{1'b1, 16'h7FFF,   32'hFFFFFFFF}, '{1'b1, 16'h7FFF,   32'h7F7FFFFF},
         '{1'b1, 16'd0,      32'h00000001}, '{1'b1, 16'h7FFF,   32'h46FFFE00},
         '{1'b1, 16'h8000,   32'hC7000000}, '{1'b1, 16'd32766,  32'h46FFFC00},
         '{1'b0, 16'd0,      32'h3EFFFFFF}, '{1'b0, 16'd0,      32'h3FBFFFFF},
         '{1'b1, 16'd127,    32'h43960000}, '{1'b1, 16'hFF80,   32'hC3960000},
         '{1'b1, 16'd127,    32'h7FC00000}, '{1'b1, 16'd127,    32'h42FE0000},
         '{1'b1, 16'hFF80,   32'hC3000000}};
      model_scale = SCALE_RESET;
      model_narrow = 1'b0;
      model_transpose = 1'b0;
      model_rows = 13'd1;
      model_cols = 13'd1;
      row_pos = 0;
      col_pos = 0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: register defaults first, then the narrow range
      for (int i = 0; i < NUM_VECTOR; i++) begin
         if (i == NUM_WIDE) program_regs(SCALE_RESET, 1'b1, 1'b0, 13'd1, 13'd1);
         send_sample(directed[i].sample, directed[i].typed, directed[i].q);
      end

      // Random phases, each with fresh register settings
      phases = 20;
      for (int ph = 0; ph < phases; ph++) begin
         if (ph == 0) begin
            program_regs(32'h3F800000, 1'b0, 1'b1, 13'd4096, 13'd4096);
         end else if (ph == 1) begin
            program_regs(32'h7F7FFFFF, 1'b1, 1'b0, 13'd8191, 13'd0);
         end else begin
            program_regs(random_scale(), 1'($urandom), 1'($urandom),
                         random_dim(), random_dim());
         end
         if (ph == phases - 1) idle_on = 1'b0;
         count = $urandom_range(60, 110);
         for (int n = 0; n < count; n++) begin
            if (ph == 4 && n == count / 2) wait_drained();
            send_sample(random_sample(), 1'b0, 16'd0);
         end
      end
      req_valid <= 1'b0;

      while (pending_results.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      $display("Covered %0d element transfers in, %0d out, over %0d register settings,",
               transfers_in, transfers_out, phases + 2);
      $display("with int16/int8 saturation, transposed indexing and special floats.");
      if (mismatches == 0) begin
         $display("PASS");
      end else begin
         $display("%0d mismatches", mismatches);
         $display("FAIL");
      end
      $finish;
   end

endmodule
